@@ sv/rope3d_pkg.sv @@
package rope3d_pkg;

  // Default sizes
  localparam int DEF_MAX_PAIRS     = 64;
  localparam int DEF_POS_BITS      = 20;
  localparam int DEF_CORDIC_STAGES = 16;

  // Field widths
  localparam int IDX_W  = 6;
  localparam int FREQ_W = 32;
  localparam int POS_W  = 20;
  localparam int DATA_W = 16;
  localparam int CFG_W  = 7;

  // CORDIC datapath: x/y in Q2.30 with headroom, residual angle signed
  localparam int CV_W   = 34;
  localparam int Z_W    = 33;
  localparam int PROD_W = DATA_W + CV_W;

  // Inverse CORDIC gain, Q2.30
  localparam logic signed [CV_W-1:0] GAIN_Q30 = 34'sh026DD3B6A;

  // Request opcodes
  typedef enum logic {
    OP_ROTATE = 1'b0,
    OP_LOAD   = 1'b1
  } opcode_t;

  // Phase quadrant, top two bits of the turn fraction
  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  // Configuration register indexes
  localparam logic REG_FREQ_ALLOC = 1'b0;
  localparam logic REG_PAIR_COUNT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] FREQ_ALLOC_RST = 7'd20;
  localparam logic [CFG_W-1:0] PAIR_COUNT_RST = 7'd64;

  typedef struct packed {
    opcode_t                   opcode;
    logic [IDX_W-1:0]          pair_index;
    logic [FREQ_W-1:0]         freq_value;
    logic [POS_W-1:0]          pos_time;
    logic [POS_W-1:0]          pos_height;
    logic [POS_W-1:0]          pos_width;
    logic signed [DATA_W-1:0]  x_even;
    logic signed [DATA_W-1:0]  x_odd;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  y_even;
    logic signed [DATA_W-1:0]  y_odd;
  } out_item_t;

  // Data handed from one CORDIC cell to the next
  typedef struct packed {
    logic signed [CV_W-1:0]    x;
    logic signed [CV_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic [1:0]                quad;
    logic signed [DATA_W-1:0]  xe;
    logic signed [DATA_W-1:0]  xo;
  } cord_t;

  // atan(2^-i) in 2^-32 turns
  function automatic logic [FREQ_W-1:0] atan_turn(input int unsigned i);
    logic [FREQ_W-1:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/rope3d_front.sv @@
module rope3d_front import rope3d_pkg::*; #(
  parameter int MAX_PAIRS = DEF_MAX_PAIRS,
  parameter int POS_BITS  = DEF_POS_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output cord_t            out_data
);

  localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PW = (POS_BITS < POS_W) ? POS_BITS : POS_W;

  // Pair index folded into the table depth by shifted compare and subtract
  function automatic logic [AW-1:0] fold_addr(input logic [IDX_W-1:0] idx);
    int a;
    a = int'(idx);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (a >= (MAX_PAIRS << k)) begin
        a = a - (MAX_PAIRS << k);
      end
    end
    return AW'(a);
  endfunction

  logic [CFG_W-1:0]         freq_alloc_r, pair_count_r;
  logic [CFG_W-1:0]         hw_end;
  logic                     use_hw;
  logic [POS_W-1:0]         pos_sel;
  logic [AW-1:0]            addr;
  logic                     accept, rot_acc, load_acc;

  logic [FREQ_W-1:0]        freq_mem [MAX_PAIRS];

  logic                     a_valid_r, a_ready;
  logic [PW-1:0]            a_pos_r;
  logic [FREQ_W-1:0]        a_freq_r;
  logic signed [DATA_W-1:0] a_xe_r, a_xo_r;

  logic                     b_valid_r, b_ready;
  logic [FREQ_W-1:0]        phase_nxt;
  cord_t                    cell_nxt, b_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_alloc_r <= FREQ_ALLOC_RST;
      pair_count_r <= PAIR_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREQ_ALLOC: freq_alloc_r <= cfg_data;
        REG_PAIR_COUNT: pair_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position select: low pairs use height/width, top pairs use time
  always_comb begin
    hw_end  = (pair_count_r > freq_alloc_r) ? pair_count_r - freq_alloc_r : '0;
    use_hw  = {1'b0, in_item.pair_index} < hw_end;
    if (use_hw) begin
      pos_sel = in_item.pair_index[0] ? in_item.pos_width : in_item.pos_height;
    end else begin
      pos_sel = in_item.pos_time;
    end
    addr = fold_addr(in_item.pair_index);
  end

  assign a_ready  = !a_valid_r || b_ready;
  assign b_ready  = !b_valid_r || out_ready;
  assign in_ready = a_ready;
  assign accept   = in_valid && in_ready;
  assign rot_acc  = accept && (in_item.opcode == OP_ROTATE);
  assign load_acc = accept && (in_item.opcode == OP_LOAD);

  // Frequency table, registered read
  always_ff @(posedge clk) begin
    if (load_acc) begin
      freq_mem[addr] <= in_item.freq_value;
    end
    if (rot_acc) begin
      a_freq_r <= freq_mem[addr];
    end
  end

  // Stage A: table read, position and pair captured
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= rot_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rot_acc) begin
      a_pos_r <= pos_sel[PW-1:0];
      a_xe_r  <= in_item.x_even;
      a_xo_r  <= in_item.x_odd;
    end
  end

  // Stage B: phase = position * step mod 2^32, CORDIC seed
  always_comb begin
    phase_nxt      = FREQ_W'(a_pos_r) * a_freq_r;
    cell_nxt.x     = GAIN_Q30;
    cell_nxt.y     = '0;
    cell_nxt.z     = signed'(Z_W'(phase_nxt[29:0]));
    cell_nxt.quad  = phase_nxt[31:30];
    cell_nxt.xe    = a_xe_r;
    cell_nxt.xo    = a_xo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_data_r <= cell_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

endmodule

@@ sv/rope3d_cordic_cell.sv @@
module rope3d_cordic_cell import rope3d_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  cord_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output cord_t out_data
);

  localparam logic [FREQ_W-1:0] ATAN = atan_turn(IDX);

  logic  valid_r;
  cord_t res_nxt, res_r;

  // One micro-rotation, direction from the sign of the residual angle
  always_comb begin
    res_nxt = in_data;
    if (!in_data.z[Z_W-1]) begin
      res_nxt.x = in_data.x - (in_data.y >>> IDX);
      res_nxt.y = in_data.y + (in_data.x >>> IDX);
      res_nxt.z = in_data.z - signed'(Z_W'(ATAN));
    end else begin
      res_nxt.x = in_data.x + (in_data.y >>> IDX);
      res_nxt.y = in_data.y - (in_data.x >>> IDX);
      res_nxt.z = in_data.z + signed'(Z_W'(ATAN));
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;

endmodule

@@ sv/rope3d_rotate.sv @@
module rope3d_rotate import rope3d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cord_t     in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic signed [PROD_W:0] RND     = (PROD_W+1)'(64'sh20000000);
  localparam logic signed [PROD_W:0] SAT_MAX = (PROD_W+1)'(64'sd32767);
  localparam logic signed [PROD_W:0] SAT_MIN = (PROD_W+1)'(-64'sd32768);

  // Round half up from Q45 to Q15 and saturate
  function automatic logic signed [DATA_W-1:0] round_sat(
    input logic signed [PROD_W:0] acc
  );
    logic signed [PROD_W:0] r;
    r = (acc + RND) >>> 30;
    if (r > SAT_MAX) begin
      return SAT_MAX[DATA_W-1:0];
    end else if (r < SAT_MIN) begin
      return SAT_MIN[DATA_W-1:0];
    end
    return r[DATA_W-1:0];
  endfunction

  logic                     m_valid_r, m_ready;
  logic signed [CV_W-1:0]   c_nxt, s_nxt, m_c_r, m_s_r;
  logic signed [DATA_W-1:0] m_xe_r, m_xo_r;

  logic                     p_valid_r, p_ready;
  logic signed [PROD_W-1:0] p_ec_r, p_es_r, p_oc_r, p_os_r;

  logic                     o_valid_r, o_ready;
  out_item_t                o_item_r, o_item_nxt;

  assign m_ready  = !m_valid_r || p_ready;
  assign p_ready  = !p_valid_r || o_ready;
  assign o_ready  = !o_valid_r || out_ready;
  assign in_ready = m_ready;

  // Quadrant fold of the CORDIC result into cos/sin
  always_comb begin
    case (quad_t'(in_data.quad))
      QUAD_I: begin
        c_nxt = in_data.x;
        s_nxt = in_data.y;
      end
      QUAD_II: begin
        c_nxt = -in_data.y;
        s_nxt = in_data.x;
      end
      QUAD_III: begin
        c_nxt = -in_data.x;
        s_nxt = -in_data.y;
      end
      default: begin
        c_nxt = in_data.y;
        s_nxt = -in_data.x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (m_ready) m_valid_r <= in_valid;
      if (p_ready) p_valid_r <= m_valid_r;
      if (o_ready) o_valid_r <= p_valid_r;
    end
  end

  // Stage M: cos/sin
  always_ff @(posedge clk) begin
    if (m_ready && in_valid) begin
      m_c_r  <= c_nxt;
      m_s_r  <= s_nxt;
      m_xe_r <= in_data.xe;
      m_xo_r <= in_data.xo;
    end
  end

  // Stage P: four products
  always_ff @(posedge clk) begin
    if (p_ready && m_valid_r) begin
      p_ec_r <= m_xe_r * m_c_r;
      p_es_r <= m_xe_r * m_s_r;
      p_oc_r <= m_xo_r * m_c_r;
      p_os_r <= m_xo_r * m_s_r;
    end
  end

  // Stage O: sums, rounding, saturation
  always_comb begin
    o_item_nxt.y_even = round_sat((PROD_W+1)'(p_ec_r) - (PROD_W+1)'(p_os_r));
    o_item_nxt.y_odd  = round_sat((PROD_W+1)'(p_oc_r) + (PROD_W+1)'(p_es_r));
  end

  always_ff @(posedge clk) begin
    if (o_ready && p_valid_r) begin
      o_item_r <= o_item_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_item  = o_item_r;

endmodule

@@ sv/rope_3d_pair_rotator.sv @@
// Registers from request accept to result valid, in order: table read, phase multiply,
//   one per CORDIC cell, fold, products, round.
// Throughput: one rotate or load request per cycle; each stage holds at most one rotate
//   request and stalls only when the stage after it is full and blocked.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets the
//   time-pair count to 20 and pair_count to 64; the frequency table is not cleared.
module rope_3d_pair_rotator import rope3d_pkg::*; #(
  parameter int MAX_PAIRS     = DEF_MAX_PAIRS,
  parameter int POS_BITS      = DEF_POS_BITS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  logic  cell_vld [CORDIC_STAGES+1];
  logic  cell_rdy [CORDIC_STAGES+1];
  cord_t cell_dat [CORDIC_STAGES+1];

  // Table, position select and phase
  rope3d_front #(
    .MAX_PAIRS (MAX_PAIRS),
    .POS_BITS  (POS_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (cell_vld[0]),
    .out_ready (cell_rdy[0]),
    .out_data  (cell_dat[0])
  );

  // Row of CORDIC cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    rope3d_cordic_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cell_vld[i]),
      .in_ready  (cell_rdy[i]),
      .in_data   (cell_dat[i]),
      .out_valid (cell_vld[i+1]),
      .out_ready (cell_rdy[i+1]),
      .out_data  (cell_dat[i+1])
    );
  end

  // Quadrant fold, rotation and output register
  rope3d_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cell_vld[CORDIC_STAGES]),
    .in_ready  (cell_rdy[CORDIC_STAGES]),
    .in_data   (cell_dat[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // An empty output stage means no stage upstream can be blocked
  a_ready_when_out_empty: assert property (
    @(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready
  ) else $error("input stalled while the output stage is empty");

  // A stall at the CORDIC entry must come from a blocked output
  a_cell_stall_source: assert property (
    @(posedge clk) disable iff (!rst_n)
      (cell_vld[0] && !cell_rdy[0]) |-> (out_valid && !out_ready)
  ) else $error("CORDIC entry stalled without a blocked output");

  // No result is presented right after reset
  a_reset_empty: assert property (
    @(posedge clk) !rst_n |=> !out_valid
  ) else $error("result valid after reset");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rope3d_pkg::*;

  localparam int CORDIC_N  = DEF_CORDIC_STAGES;
  localparam int LATENCY   = CORDIC_N + 5;
  localparam int MAX_CYCLES = 400000;

  // Inverse CORDIC gain in Q2.30 and the arctangent steps in 2^-32 turns
  localparam longint INV_GAIN = 64'sh26DD3B6A;
  localparam logic [31:0] ATAN_STEP [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;

  rope_3d_pair_rotator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Local copy of the block state
  logic [FREQ_W-1:0] freq_steps [DEF_MAX_PAIRS];
  bit                step_loaded [DEF_MAX_PAIRS];
  logic [CFG_W-1:0]  cfg_alloc;
  logic [CFG_W-1:0]  cfg_pairs;
  out_item_t         rotated_q [$];

  bit calm;
  bit ready_now;
  int ready_left;
  int n_errors;
  int n_results;
  int n_sent;
  int n_loads;
  int n_settings;
  int n_cycles;

  // Round half up from Q45 and clamp to Q1.15
  function automatic logic signed [DATA_W-1:0] sat_q15(input longint acc);
    longint r;
    r = (acc + (longint'(1) <<< 29)) >>> 30;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return DATA_W'(r);
  endfunction

  // Expected rotated pair for one rotate request
  function automatic out_item_t rotate_pair(input in_item_t req);
    int unsigned      hw_end;
    logic [POS_W-1:0] pos;
    logic [63:0]      turn;
    logic [31:0]      phase;
    longint           x, y, z, dx, dy, c, s, xe, xo;
    out_item_t        res;
    hw_end = (cfg_pairs > cfg_alloc) ? cfg_pairs - cfg_alloc : 0;
    if (req.pair_index < hw_end) pos = req.pair_index[0] ? req.pos_width : req.pos_height;
    else pos = req.pos_time;
    turn  = 64'(pos) * 64'(freq_steps[req.pair_index]);
    phase = turn[31:0];
    x = INV_GAIN;
    y = 0;
    z = longint'(phase[29:0]);
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_STEP[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_STEP[i]);
      end
    end
    case (quad_t'(phase[31:30]))
      QUAD_I:   begin c = x;  s = y;  end
      QUAD_II:  begin c = -y; s = x;  end
      QUAD_III: begin c = -x; s = -y; end
      default:  begin c = y;  s = -x; end
    endcase
    xe = longint'(req.x_even);
    xo = longint'(req.x_odd);
    res.y_even = sat_q15(xe * c - xo * s);
    res.y_odd  = sat_q15(xo * c + xe * s);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 35) return POS_W'($urandom_range(0, 63));
    return POS_W'($urandom);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'sh8000;
    if (r < 20) return 16'sh7FFF;
    return DATA_W'($urandom);
  endfunction

  function automatic logic [FREQ_W-1:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return FREQ_W'($urandom_range(0, 255));
    if (r < 15) return '1;
    return $urandom;
  endfunction

  function automatic in_item_t make_load(input int idx, input logic [FREQ_W-1:0] step);
    in_item_t req;
    req = '0;
    req.opcode     = OP_LOAD;
    req.pair_index = IDX_W'(idx);
    req.freq_value = step;
    return req;
  endfunction

  function automatic in_item_t make_rotate(input int idx, input logic [POS_W-1:0] pt,
                                           input logic [POS_W-1:0] ph,
                                           input logic [POS_W-1:0] pw,
                                           input logic signed [DATA_W-1:0] xe,
                                           input logic signed [DATA_W-1:0] xo);
    in_item_t req;
    req = '0;
    req.opcode     = OP_ROTATE;
    req.pair_index = IDX_W'(idx);
    req.pos_time   = pt;
    req.pos_height = ph;
    req.pos_width  = pw;
    req.x_even     = xe;
    req.x_odd      = xo;
    return req;
  endfunction

  // Present one request, wait for accept, then record what it should do
  task automatic send_request(input in_item_t req);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    if (req.opcode == OP_LOAD) begin
      freq_steps[req.pair_index]  = req.freq_value;
      step_loaded[req.pair_index] = 1'b1;
      n_loads++;
    end else begin
      rotated_q.push_back(rotate_pair(req));
    end
  endtask

  // Let every result come out and any trailing load settle
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] fa, input logic [CFG_W-1:0] pc);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FREQ_ALLOC;
    cfg_data  <= fa;
    @(posedge clk);
    cfg_index <= REG_PAIR_COUNT;
    cfg_data  <= pc;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_alloc = fa;
    cfg_pairs = pc;
    n_settings++;
  endtask

  // Random mix; never rotates an entry that was not loaded yet
  task automatic run_random(input int count);
    in_item_t req;
    for (int n = 0; n < count; n++) begin
      req.opcode     = ($urandom_range(0, 99) < 20) ? OP_LOAD : OP_ROTATE;
      req.pair_index = IDX_W'($urandom_range(0, DEF_MAX_PAIRS - 1));
      if (!step_loaded[req.pair_index]) req.opcode = OP_LOAD;
      req.freq_value = pick_step();
      req.pos_time   = pick_pos();
      req.pos_height = pick_pos();
      req.pos_width  = pick_pos();
      req.x_even     = pick_sample();
      req.x_odd      = pick_sample();
      send_request(req);
    end
  endtask

  // Table loads with boundary steps and addresses
  task automatic test_table_loads();
    send_request(make_load(0, 32'h00000000));
    send_request(make_load(1, 32'h40000000));
    send_request(make_load(2, 32'h80000000));
    send_request(make_load(3, 32'hC0000000));
    send_request(make_load(63, 32'hFFFFFFFF));
    send_request(make_load(44, 32'h01000000));
    send_request(make_load(43, 32'h12345678));
    send_request(make_load(62, 32'h00000001));
  endtask

  // Each quadrant, zero angle, wrap of the phase and saturation at reset setting
  task automatic test_quadrants_and_saturation();
    send_request(make_rotate(0, '1, '1, '1, 16'sh7FFF, 16'sh8000));
    send_request(make_rotate(0, 20'd5, 20'd9, 20'd3, 16'sh8000, 16'sh8000));
    send_request(make_rotate(1, 20'd0, 20'd0, 20'd1, 16'sh8000, 16'sd100));
    send_request(make_rotate(2, 20'd0, 20'd1, 20'd0, 16'sh8000, 16'sh8000));
    send_request(make_rotate(3, 20'd0, 20'd1, 20'd0, 16'sh7FFF, 16'sh8000));
    send_request(make_rotate(3, 20'd0, 20'd3, 20'd0, 16'sh7FFF, 16'sh7FFF));
    send_request(make_rotate(63, '1, 20'd0, 20'd0, 16'sh8000, 16'sh7FFF));
    send_request(make_rotate(44, 20'h20, 20'd1, 20'd2, 16'sh7FFF, 16'sh7FFF));
    send_request(make_rotate(43, 20'd0, 20'd0, '1, 16'sd1, 16'sh8001));
    send_request(make_rotate(62, '1, 20'd0, 20'd0, 16'sd0, 16'sd0));
    send_request(make_rotate(2, 20'd0, 20'd0, 20'd7, 16'sh7FFF, 16'sd0));
  endtask

  // Split point of time vs height/width positions over several register settings
  task automatic test_position_split();
    apply_setting(7'd0, 7'd64);
    run_random(50);
    apply_setting(7'd64, 7'd64);
    run_random(50);
    apply_setting(7'd64, 7'd1);
    run_random(50);
    apply_setting(7'd0, 7'd1);
    run_random(50);
    apply_setting(7'd30, 7'd20);
    run_random(50);
    apply_setting(7'd7, 7'd40);
    run_random(50);
    apply_setting(FREQ_ALLOC_RST, PAIR_COUNT_RST);
    run_random(50);
  endtask

  // Back-to-back requests with the output always ready
  task automatic test_calm_stream();
    apply_setting(7'd33, 7'd57);
    calm = 1'b1;
    run_random(50);
    calm = 1'b0;
  endtask

  // Output side: random back-pressure and comparison against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (rotated_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result: y_even=%0d y_odd=%0d", out_item.y_even, out_item.y_odd);
      end else begin
        want = rotated_q.pop_front();
        if (out_item.y_even !== want.y_even || out_item.y_odd !== want.y_odd) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result %0d mismatch: y_even exp %0d got %0d, y_odd exp %0d got %0d",
                     n_results, want.y_even, out_item.y_even, want.y_odd, out_item.y_odd);
        end
      end
    end
    if (ready_left == 0) begin
      if (calm) begin
        ready_now  = 1'b1;
        ready_left = 1;
      end else if ($urandom_range(0, 99) < 70) begin
        ready_now  = 1'b1;
        ready_left = $urandom_range(1, 16);
      end else begin
        ready_now  = 1'b0;
        ready_left = 1 + idle_len();
      end
    end
    ready_left--;
    out_ready <= ready_now;
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles, rotated_q.size());
      $display("** rope_3d_pair_rotator: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_FREQ_ALLOC;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_item    = '0;
    out_ready  = 1'b0;
    calm       = 1'b0;
    ready_now  = 1'b0;
    ready_left = 0;
    cfg_alloc  = FREQ_ALLOC_RST;
    cfg_pairs  = PAIR_COUNT_RST;
    for (int i = 0; i < DEF_MAX_PAIRS; i++) begin
      freq_steps[i]  = '0;
      step_loaded[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_loads();
    test_quadrants_and_saturation();
    test_position_split();
    test_calm_stream();
    drain_pipeline();

    $display("Sent %0d requests (%0d table loads) under %0d register settings plus reset values.",
             n_sent, n_loads, n_settings);
    $display("Checked %0d rotated pairs, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0 && rotated_q.size() == 0) begin
      $display("** rope_3d_pair_rotator: PASSED **");
    end else begin
      $display("** rope_3d_pair_rotator: FAILED **");
    end
    $finish;
  end

endmodule
